>>> src/apr_pkg.sv
// shared types and constants for the aging page replacement block
package apr_pkg;

  localparam int unsigned FRAMES_DEF    = 16;
  localparam int unsigned PAGE_BITS_DEF = 12;

  localparam int unsigned AGE_W   = 16;
  localparam int unsigned CFG_W   = 5;
  localparam int unsigned IDX_OUT_W = 4;
  localparam int unsigned FAULT_W = 32;

  localparam logic [AGE_W-1:0]   AGE_TOP     = 16'h8000;
  localparam logic [CFG_W-1:0]   CFG_RESET   = 5'd16;
  localparam logic [FAULT_W-1:0] FAULT_MAX   = 32'hFFFF_FFFF;

  // controller to datapath
  typedef struct packed {
    logic start;   // latch request, clear scan flags
    logic scan;    // issue a read at the scan index
    logic commit;  // final write-back and result load
  } apr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic page_zero;  // incoming request is the empty marker
    logic scan_last;  // scan index is at the last frame in use
  } apr_status_t;

endpackage

>>> src/apr_ctrl.sv
// sequencer for one page reference: scan, drain, commit
module apr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  apr_pkg::apr_status_t status,
  output apr_pkg::apr_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_t;

  state_t state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= status.page_zero ? S_COMMIT : S_SCAN;
          end
        end
        S_SCAN: begin
          if (status.scan_last) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN:  state_r <= S_COMMIT;
        S_COMMIT: state_r <= S_IDLE;
        default:  state_r <= S_IDLE;
      endcase
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign cmd.start  = start && (state_r == S_IDLE);
  assign cmd.scan   = (state_r == S_SCAN);
  assign cmd.commit = (state_r == S_COMMIT);

endmodule

>>> src/apr_dp.sv
// frame table, aging counters, scan compare and fault counter
module apr_dp #(
  parameter int unsigned FRAMES    = apr_pkg::FRAMES_DEF,
  parameter int unsigned PAGE_BITS = apr_pkg::PAGE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [apr_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic [PAGE_BITS-1:0]          in_page_number,
  input  apr_pkg::apr_cmd_t             cmd,
  output apr_pkg::apr_status_t          status,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic [apr_pkg::IDX_OUT_W-1:0] out_frame_index,
  output logic [PAGE_BITS-1:0]          out_evicted_page,
  output logic [apr_pkg::FAULT_W-1:0]   out_fault_count
);

  localparam int unsigned IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned AGE_W = apr_pkg::AGE_W;

  // storage
  logic [PAGE_BITS-1:0] page_mem [FRAMES];
  logic [AGE_W-1:0]     age_mem  [FRAMES];
  logic [FRAMES-1:0]    pv_r;
  logic [FRAMES-1:0]    av_r;

  logic [apr_pkg::CFG_W-1:0]   cfg_frames_r;
  logic [PAGE_BITS-1:0]        page_r;
  logic [IDX_W-1:0]            last_r;
  logic [IDX_W-1:0]            rd_idx_r;
  logic [IDX_W-1:0]            cmp_idx_r;
  logic                        cmp_vld_r;
  logic [PAGE_BITS-1:0]        page_q_r;
  logic                        page_qv_r;
  logic [AGE_W-1:0]            age_q_r;
  logic                        age_qv_r;

  logic                        hit_r;
  logic [IDX_W-1:0]            slot_r;
  logic                        empty_found_r;
  logic [IDX_W-1:0]            empty_at_r;
  logic [IDX_W-1:0]            min_at_r;
  logic [AGE_W-1:0]            min_age_r;
  logic [PAGE_BITS-1:0]        min_page_r;
  logic [apr_pkg::FAULT_W-1:0] faults_r;

  logic                          out_valid_r;
  logic                          out_hit_r;
  logic [apr_pkg::IDX_OUT_W-1:0] out_idx_r;
  logic [PAGE_BITS-1:0]          out_evict_r;
  logic [apr_pkg::FAULT_W-1:0]   out_faults_r;

  // compare stage signals
  logic [PAGE_BITS-1:0]        pg_rd;
  logic [AGE_W-1:0]            aged;
  logic                        first_hit;
  logic                        take_empty;
  logic                        take_min;
  logic                        page_ok;
  logic                        miss_wr;
  logic [IDX_W-1:0]            slot_fin;
  logic                        age_we;
  logic [IDX_W-1:0]            age_waddr;
  logic [AGE_W-1:0]            age_wdata;
  logic [apr_pkg::FAULT_W-1:0] faults_nxt;
  logic [31:0]                 cfg_ext;
  logic [31:0]                 n_lim;

  // clamp frames in use to 1..FRAMES
  always_comb begin
    cfg_ext = {{(32-apr_pkg::CFG_W){1'b0}}, cfg_frames_r};
    if (cfg_ext == 32'd0) begin
      n_lim = 32'd1;
    end else if (cfg_ext > 32'(FRAMES)) begin
      n_lim = 32'(FRAMES);
    end else begin
      n_lim = cfg_ext;
    end
  end

  assign status.page_zero = (in_page_number == '0);
  assign status.scan_last = (rd_idx_r == last_r);

  always_comb begin
    pg_rd      = page_qv_r ? page_q_r : '0;
    aged       = (age_qv_r ? age_q_r : '0) >> 1;
    first_hit  = cmp_vld_r && !hit_r && (pg_rd == page_r);
    take_empty = cmp_vld_r && !empty_found_r && (pg_rd == '0);
    take_min   = cmp_vld_r && ((cmp_idx_r == '0) || (aged < min_age_r));
    page_ok    = (page_r != '0);
    miss_wr    = cmd.commit && page_ok && !hit_r;
    slot_fin   = hit_r ? slot_r : (empty_found_r ? empty_at_r : min_at_r);

    // scan writes back the aged counter, commit clears the refilled one
    age_we    = cmp_vld_r || miss_wr;
    age_waddr = cmp_vld_r ? cmp_idx_r : slot_fin;
    age_wdata = cmp_vld_r ? (aged | (first_hit ? apr_pkg::AGE_TOP : '0)) : '0;

    faults_nxt = faults_r;
    if (page_ok && !hit_r && (faults_r != apr_pkg::FAULT_MAX)) begin
      faults_nxt = faults_r + 1'b1;
    end
  end

  // memories: registered reads, writes at one address a cycle
  always_ff @(posedge clk) begin
    page_q_r <= page_mem[rd_idx_r];
    age_q_r  <= age_mem[rd_idx_r];
    if (miss_wr) begin
      page_mem[slot_fin] <= page_r;
    end
    if (age_we) begin
      age_mem[age_waddr] <= age_wdata;
    end
  end

  // control and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r          <= '0;
      av_r          <= '0;
      cfg_frames_r  <= apr_pkg::CFG_RESET;
      cmp_vld_r     <= 1'b0;
      page_qv_r     <= 1'b0;
      age_qv_r      <= 1'b0;
      hit_r         <= 1'b0;
      empty_found_r <= 1'b0;
      faults_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_frames_r <= cfg_wr_data;
      end
      cmp_vld_r   <= cmd.scan;
      page_qv_r   <= pv_r[rd_idx_r];
      age_qv_r    <= av_r[rd_idx_r];
      out_valid_r <= cmd.commit;
      if (miss_wr) begin
        pv_r[slot_fin] <= 1'b1;
      end
      if (age_we) begin
        av_r[age_waddr] <= 1'b1;
      end
      if (cmd.start) begin
        hit_r         <= 1'b0;
        empty_found_r <= 1'b0;
      end else begin
        if (first_hit) begin
          hit_r <= 1'b1;
        end
        if (take_empty) begin
          empty_found_r <= 1'b1;
        end
      end
      if (cmd.commit) begin
        faults_r <= faults_nxt;
      end
    end
  end

  // scan payload
  always_ff @(posedge clk) begin
    cmp_idx_r <= rd_idx_r;
    if (cmd.start) begin
      page_r     <= in_page_number;
      last_r     <= IDX_W'(n_lim - 32'd1);
      rd_idx_r   <= '0;
      slot_r     <= '0;
      empty_at_r <= '0;
      min_at_r   <= '0;
      min_age_r  <= '0;
      min_page_r <= '0;
    end else begin
      if (cmd.scan) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
      if (first_hit) begin
        slot_r <= cmp_idx_r;
      end
      if (take_empty) begin
        empty_at_r <= cmp_idx_r;
      end
      if (take_min) begin
        min_at_r   <= cmp_idx_r;
        min_age_r  <= aged;
        min_page_r <= pg_rd;
      end
    end
    if (cmd.commit) begin
      out_hit_r    <= hit_r;
      out_idx_r    <= apr_pkg::IDX_OUT_W'(page_ok ? slot_fin : '0);
      out_evict_r  <= (page_ok && !hit_r && !empty_found_r) ? min_page_r : '0;
      out_faults_r <= faults_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_frame_index  = out_idx_r;
  assign out_evicted_page = out_evict_r;
  assign out_fault_count  = out_faults_r;

endmodule

>>> src/aging_page_replacement.sv
// top level of the aging page replacement block
//
//   channel   ports                                         handshake
//   request   in_page_number                                in_start, busy
//   result    out_hit, out_frame_index, out_evicted_page,   out_valid (one-cycle strobe)
//             out_fault_count
//   config    cfg_wr_data                                   cfg_wr_en
//
// a request scans the n frames in use (1..FRAMES), one frame per cycle read from the
// frame and age memories, then passes a drain state for the registered read, a commit
// state and the result register before its result strobe. page zero goes straight to
// commit and answers with no state change.
// reset clears the valid bits of both memories at once and sets frames in use to 16.
// busy stays high until the commit; results are never held back.
module aging_page_replacement #(
  parameter int unsigned FRAMES    = apr_pkg::FRAMES_DEF,
  parameter int unsigned PAGE_BITS = apr_pkg::PAGE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [apr_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                          in_start,
  input  logic [PAGE_BITS-1:0]          in_page_number,
  output logic                          busy,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic [apr_pkg::IDX_OUT_W-1:0] out_frame_index,
  output logic [PAGE_BITS-1:0]          out_evicted_page,
  output logic [apr_pkg::FAULT_W-1:0]   out_fault_count
);

  apr_pkg::apr_cmd_t    cmd;
  apr_pkg::apr_status_t status;

  apr_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  apr_dp #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_page_number   (in_page_number),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_frame_index  (out_frame_index),
    .out_evicted_page (out_evicted_page),
    .out_fault_count  (out_fault_count)
  );

  // every commit yields exactly one result strobe
  a_commit_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("commit without result strobe");

  // result strobes never come on consecutive cycles
  a_no_double: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe on consecutive cycles");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (out_evicted_page == '0))
    else $error("eviction reported on a hit");

  // scan and commit only while busy
  a_busy_cover: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan || cmd.commit) |-> busy)
    else $error("datapath command while idle");

endmodule
